>>> rtl/msw_pkg.sv
package msw_pkg;

  localparam int unsigned TicksW = 32;
  localparam int unsigned DetailW = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [TicksW-1:0] CalibLimitRst = 32'd60000;
  localparam logic [TicksW-1:0] ModeLimitRst = 32'd300000;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_MANUAL = 4'd1,
    MODE_CALIB  = 4'd2,
    MODE_MOW    = 4'd3,
    MODE_TURN   = 4'd4,
    MODE_AVOID  = 4'd5,
    MODE_RETURN = 4'd6,
    MODE_SEARCH = 4'd7,
    MODE_CHARGE = 4'd8,
    MODE_ERROR  = 4'd9
  } mode_e;

  typedef enum logic [3:0] {
    ACT_TICK    = 4'd0,
    ACT_BEGIN   = 4'd1,
    ACT_SET     = 4'd2,
    ACT_START   = 4'd3,
    ACT_PAUSE   = 4'd4,
    ACT_STOP    = 4'd5,
    ACT_RETURN  = 4'd6,
    ACT_SEARCH  = 4'd7,
    ACT_ERROR   = 4'd8,
    ACT_RECOVER = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_CALIB_TO = 2'd1,
    CAUSE_MODE_TO  = 2'd2,
    CAUSE_EXTERNAL = 2'd3
  } cause_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CALIB_LIMIT = 1'd0,
    REG_MODE_LIMIT  = 1'd1
  } reg_idx_e;

  typedef struct packed {
    mode_e              mode;
    mode_e              prior;
    logic               ready_flag;
    logic [TicksW-1:0]  ticks;
    cause_e             cause;
    logic [DetailW-1:0] detail;
  } state_t;

  typedef struct packed {
    logic [TicksW-1:0] calib_limit;
    logic [TicksW-1:0] mode_limit;
  } limits_t;

endpackage

>>> rtl/msw_in_if.sv
interface msw_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [3:0] target_mode;
  logic [7:0] error_detail;

  modport source (output valid, action, target_mode, error_detail, input ready);
  modport sink (input valid, action, target_mode, error_detail, output ready);
endinterface

>>> rtl/msw_out_if.sv
interface msw_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode_now;
  logic [3:0]  mode_before;
  logic        mode_changed;
  logic        is_active;
  logic        in_error;
  logic [1:0]  error_cause;
  logic [7:0]  error_code;
  logic [31:0] ticks_in_mode;

  modport source (output valid, mode_now, mode_before, mode_changed, is_active, in_error,
                  error_cause, error_code, ticks_in_mode, input ready);
  modport sink (input valid, mode_now, mode_before, mode_changed, is_active, in_error,
                error_cause, error_code, ticks_in_mode, output ready);
endinterface

>>> rtl/msw_cfg_if.sv
interface msw_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/mode_supervisor_with_watchdog.sv
// Mode supervisor with time-in-mode watchdog.
//
// Channels:
//   in_i  : one action per transfer (tick, begin, set mode, start, pause,
//           stop, return, search, raise error, recover) with target mode
//           and error detail.
//   out_o : one result per accepted action, the state after that action.
//   cfg_i : register writes; index 0 calibration limit, index 1 mode limit.
//           Always ready, takes effect on the next action.
// Result: registered, presented in the cycle after the input transfer.
// Throughput: one action per cycle while out_o.ready is high. Next state
// is one saturating 32-bit increment, two limit compares and mode-select
// logic ahead of the state and result registers.
// Stall: the result register holds while out_o.ready is low; a new action
// is taken whenever that register is empty or being drained in the same
// cycle, so in_i.ready follows out_o.ready when a result is pending.
// Reset: mode idle, not initialized, ticks and fault cleared, limits back
// to 60000 and 300000 ticks. No result is pending.
module mode_supervisor_with_watchdog (
  input logic      clk_i,
  input logic      rst_ni,
  msw_in_if.sink   in_i,
  msw_out_if.source out_o,
  msw_cfg_if.sink  cfg_i
);

  msw_pkg::state_t  state_q, state_d;
  msw_pkg::limits_t lim_q;
  logic             out_valid_q;
  logic             in_xfer;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.calib_limit <= msw_pkg::CalibLimitRst;
      lim_q.mode_limit  <= msw_pkg::ModeLimitRst;
    end else if (cfg_i.valid) begin
      case (msw_pkg::reg_idx_e'(cfg_i.index))
        msw_pkg::REG_CALIB_LIMIT: lim_q.calib_limit <= cfg_i.data;
        msw_pkg::REG_MODE_LIMIT:  lim_q.mode_limit  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // accept whenever the result register frees up this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  msw_next u_next (
    .cur_i    (state_q),
    .lim_i    (lim_q),
    .action_i (in_i.action),
    .target_i (in_i.target_mode),
    .detail_i (in_i.error_detail),
    .nxt_o    (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode       <= msw_pkg::MODE_IDLE;
      state_q.prior      <= msw_pkg::MODE_IDLE;
      state_q.ready_flag <= 1'b0;
      state_q.ticks      <= '0;
      state_q.cause      <= msw_pkg::CAUSE_NONE;
      state_q.detail     <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_o.mode_now      <= state_d.mode;
      out_o.mode_before   <= state_d.prior;
      out_o.mode_changed  <= (state_d.mode != state_q.mode);
      out_o.is_active     <= (state_d.mode inside {[msw_pkg::MODE_MOW:msw_pkg::MODE_SEARCH]});
      out_o.in_error      <= (state_d.mode == msw_pkg::MODE_ERROR);
      out_o.error_cause   <= state_d.cause;
      out_o.error_code    <= state_d.detail;
      out_o.ticks_in_mode <= state_d.ticks;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

>>> rtl/msw_next.sv
// Next-state logic: guarded mode commands and the tick watchdog.
module msw_next (
  input  msw_pkg::state_t  cur_i,
  input  msw_pkg::limits_t lim_i,
  input  logic [3:0]       action_i,
  input  logic [3:0]       target_i,
  input  logic [7:0]       detail_i,
  output msw_pkg::state_t  nxt_o
);

  logic                           go_req;
  msw_pkg::mode_e                 go_mode;
  logic [msw_pkg::TicksW-1:0]     ticks_inc;
  logic                           supervised;

  always_comb begin
    nxt_o      = cur_i;
    go_req     = 1'b0;
    go_mode    = msw_pkg::MODE_IDLE;
    ticks_inc  = (cur_i.ticks == '1) ? cur_i.ticks : cur_i.ticks + 1'b1;
    supervised = (cur_i.mode inside {[msw_pkg::MODE_CALIB:msw_pkg::MODE_SEARCH]});

    case (msw_pkg::action_e'(action_i))
      msw_pkg::ACT_TICK: begin
        if (cur_i.ready_flag) begin
          nxt_o.ticks = ticks_inc;
          if (cur_i.mode == msw_pkg::MODE_CALIB && ticks_inc > lim_i.calib_limit) begin
            nxt_o.cause  = msw_pkg::CAUSE_CALIB_TO;
            nxt_o.detail = '0;
            go_req       = 1'b1;
            go_mode      = msw_pkg::MODE_ERROR;
          end else if (supervised && ticks_inc > lim_i.mode_limit) begin
            nxt_o.cause  = msw_pkg::CAUSE_MODE_TO;
            nxt_o.detail = '0;
            go_req       = 1'b1;
            go_mode      = msw_pkg::MODE_ERROR;
          end
        end
      end
      msw_pkg::ACT_BEGIN: begin
        nxt_o.mode       = msw_pkg::MODE_IDLE;
        nxt_o.prior      = msw_pkg::MODE_IDLE;
        nxt_o.ticks      = '0;
        nxt_o.ready_flag = 1'b1;
      end
      msw_pkg::ACT_SET: begin
        if (target_i <= msw_pkg::MODE_ERROR) begin
          go_req  = 1'b1;
          go_mode = msw_pkg::mode_e'(target_i);
        end
      end
      msw_pkg::ACT_START: begin
        go_req  = (cur_i.mode != msw_pkg::MODE_ERROR);
        go_mode = msw_pkg::MODE_MOW;
      end
      msw_pkg::ACT_PAUSE: begin
        go_req  = (cur_i.mode inside {msw_pkg::MODE_MOW, msw_pkg::MODE_TURN,
                                      msw_pkg::MODE_AVOID});
        go_mode = msw_pkg::MODE_IDLE;
      end
      msw_pkg::ACT_STOP: begin
        go_req  = (cur_i.mode != msw_pkg::MODE_IDLE && cur_i.mode != msw_pkg::MODE_ERROR);
        go_mode = msw_pkg::MODE_IDLE;
      end
      msw_pkg::ACT_RETURN: begin
        go_req  = (cur_i.mode != msw_pkg::MODE_ERROR);
        go_mode = msw_pkg::MODE_RETURN;
      end
      msw_pkg::ACT_SEARCH: begin
        go_req  = (cur_i.mode != msw_pkg::MODE_ERROR);
        go_mode = msw_pkg::MODE_SEARCH;
      end
      msw_pkg::ACT_ERROR: begin
        // cause and detail latch even when not ready or already faulted
        nxt_o.cause  = msw_pkg::CAUSE_EXTERNAL;
        nxt_o.detail = detail_i;
        go_req       = 1'b1;
        go_mode      = msw_pkg::MODE_ERROR;
      end
      msw_pkg::ACT_RECOVER: begin
        if (cur_i.mode == msw_pkg::MODE_ERROR) begin
          nxt_o.cause  = msw_pkg::CAUSE_NONE;
          nxt_o.detail = '0;
          go_req       = 1'b1;
          go_mode      = msw_pkg::MODE_IDLE;
        end
      end
      default: ;
    endcase

    // common mode-change path: only once initialized, only to a new mode
    if (go_req && cur_i.ready_flag && go_mode != cur_i.mode) begin
      nxt_o.prior = cur_i.mode;
      nxt_o.mode  = go_mode;
      nxt_o.ticks = '0;
    end
  end

endmodule

>>> verif/mode_supervisor_with_watchdog_test.sv
module mode_supervisor_with_watchdog_test;

  // Run length guard, in clock cycles. About 1.1k commands at worst
  // each take a send gap, a result stall and the transfer itself,
  // plus config writes and drain pauses.
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned NumPhases = 6;

  // One command as it goes on the wire. Action stays a raw nibble so
  // that the unused codes 10..15 can be sent.
  typedef struct packed {
    logic [3:0] act;
    logic [3:0] tgt;
    logic [7:0] det;
  } command_t;

  // Supervisor status after one command, one field per output.
  typedef struct packed {
    logic [3:0]                 mode_now;
    logic [3:0]                 mode_before;
    logic                       changed;
    logic                       active;
    logic                       err;
    logic [1:0]                 cause;
    logic [7:0]                 code;
    logic [msw_pkg::TicksW-1:0] ticks;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  msw_in_if  cmd_bus ();
  msw_out_if status_bus ();
  msw_cfg_if limit_bus ();

  mode_supervisor_with_watchdog i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_bus),
    .out_o  (status_bus),
    .cfg_i  (limit_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Supervisor shadow: limits, mode, watchdog counter and fault record.
  logic [msw_pkg::TicksW-1:0]  calib_limit_q = msw_pkg::CalibLimitRst;
  logic [msw_pkg::TicksW-1:0]  mode_limit_q = msw_pkg::ModeLimitRst;
  msw_pkg::mode_e              sup_mode = msw_pkg::MODE_IDLE;
  msw_pkg::mode_e              sup_prior = msw_pkg::MODE_IDLE;
  logic                        sup_armed = 1'b0;
  logic [msw_pkg::TicksW-1:0]  sup_ticks = '0;
  msw_pkg::cause_e             sup_cause = msw_pkg::CAUSE_NONE;
  logic [msw_pkg::DetailW-1:0] sup_detail = '0;

  command_t pending_cmds[$];
  status_t  expected_status[$];

  // Traffic shaping and bookkeeping.
  logic        idle_on = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned cycle_count = 0;
  int unsigned commands_sent = 0;
  int unsigned results_checked = 0;
  int unsigned calib_trips = 0;
  int unsigned mode_trips = 0;
  int unsigned error_count = 0;

  // Mode switch only once armed by begin and only to a different mode;
  // the watchdog count restarts with each switch.
  function automatic void switch_mode(msw_pkg::mode_e m);
    if (sup_armed && m != sup_mode) begin
      sup_prior = sup_mode;
      sup_mode  = m;
      sup_ticks = '0;
    end
  endfunction

  // Fault record is written even when the mode cannot follow.
  function automatic void enter_fault(msw_pkg::cause_e c, logic [msw_pkg::DetailW-1:0] d);
    sup_cause  = c;
    sup_detail = d;
    if (c == msw_pkg::CAUSE_CALIB_TO) calib_trips++;
    if (c == msw_pkg::CAUSE_MODE_TO) mode_trips++;
    switch_mode(msw_pkg::MODE_ERROR);
  endfunction

  // Applies one command to the shadow and returns the status it yields.
  function automatic status_t advance_supervisor(logic [3:0] act, logic [3:0] tgt,
                                                 logic [7:0] det);
    msw_pkg::mode_e entry_mode;
    status_t        st;
    entry_mode = sup_mode;
    case (act)
      msw_pkg::ACT_TICK: begin
        if (sup_armed) begin
          if (sup_ticks != '1) sup_ticks = sup_ticks + 1'b1;
          // calibration limit is checked first, general limit second
          if (sup_mode == msw_pkg::MODE_CALIB && sup_ticks > calib_limit_q) begin
            enter_fault(msw_pkg::CAUSE_CALIB_TO, '0);
          end else if (sup_mode >= msw_pkg::MODE_CALIB && sup_mode <= msw_pkg::MODE_SEARCH &&
                       sup_ticks > mode_limit_q) begin
            enter_fault(msw_pkg::CAUSE_MODE_TO, '0);
          end
        end
      end
      msw_pkg::ACT_BEGIN: begin
        // re-arm; fault record survives
        sup_mode  = msw_pkg::MODE_IDLE;
        sup_prior = msw_pkg::MODE_IDLE;
        sup_ticks = '0;
        sup_armed = 1'b1;
      end
      msw_pkg::ACT_SET: begin
        if (tgt <= msw_pkg::MODE_ERROR) switch_mode(msw_pkg::mode_e'(tgt));
      end
      msw_pkg::ACT_START: begin
        if (sup_mode != msw_pkg::MODE_ERROR) switch_mode(msw_pkg::MODE_MOW);
      end
      msw_pkg::ACT_PAUSE: begin
        if (sup_mode == msw_pkg::MODE_MOW || sup_mode == msw_pkg::MODE_TURN ||
            sup_mode == msw_pkg::MODE_AVOID) begin
          switch_mode(msw_pkg::MODE_IDLE);
        end
      end
      msw_pkg::ACT_STOP: begin
        if (sup_mode != msw_pkg::MODE_IDLE && sup_mode != msw_pkg::MODE_ERROR) begin
          switch_mode(msw_pkg::MODE_IDLE);
        end
      end
      msw_pkg::ACT_RETURN: begin
        if (sup_mode != msw_pkg::MODE_ERROR) switch_mode(msw_pkg::MODE_RETURN);
      end
      msw_pkg::ACT_SEARCH: begin
        if (sup_mode != msw_pkg::MODE_ERROR) switch_mode(msw_pkg::MODE_SEARCH);
      end
      msw_pkg::ACT_ERROR: begin
        enter_fault(msw_pkg::CAUSE_EXTERNAL, det);
      end
      msw_pkg::ACT_RECOVER: begin
        if (sup_mode == msw_pkg::MODE_ERROR) begin
          sup_cause  = msw_pkg::CAUSE_NONE;
          sup_detail = '0;
          switch_mode(msw_pkg::MODE_IDLE);
        end
      end
      default: ;  // unused codes leave everything alone
    endcase
    st.mode_now    = sup_mode;
    st.mode_before = sup_prior;
    st.changed     = (sup_mode != entry_mode);
    st.active      = (sup_mode >= msw_pkg::MODE_MOW && sup_mode <= msw_pkg::MODE_SEARCH);
    st.err         = (sup_mode == msw_pkg::MODE_ERROR);
    st.cause       = sup_cause;
    st.code        = sup_detail;
    st.ticks       = sup_ticks;
    return st;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Command driver: predicts on each accepted transfer, then presents
  // the next queued command unless a send gap is running.
  always @(posedge clk_i or negedge rst_ni) begin : command_driver
    command_t nxt;
    if (!rst_ni) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        expected_status.push_back(advance_supervisor(cmd_bus.action, cmd_bus.target_mode,
                                                     cmd_bus.error_detail));
        commands_sent++;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_bus.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          // random burst of idle cycles
          send_gap = $urandom_range(0, 4);
          cmd_bus.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          nxt = pending_cmds.pop_front();
          cmd_bus.action       <= nxt.act;
          cmd_bus.target_mode  <= nxt.tgt;
          cmd_bus.error_detail <= nxt.det;
          cmd_bus.valid        <= 1'b1;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Status monitor: checks each result transfer against the oldest
  // prediction and throttles ready in bursts.
  always @(posedge clk_i or negedge rst_ni) begin : status_monitor
    status_t want;
    if (!rst_ni) begin
      status_bus.ready <= 1'b0;
    end else begin
      if (status_bus.valid && status_bus.ready) begin
        if (expected_status.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected, expected nothing, actual mode %0d",
                   $time, status_bus.mode_now);
        end else begin
          want = expected_status.pop_front();
          results_checked++;
          check_field("mode_now", want.mode_now, status_bus.mode_now);
          check_field("mode_before", want.mode_before, status_bus.mode_before);
          check_field("mode_changed", want.changed, status_bus.mode_changed);
          check_field("is_active", want.active, status_bus.is_active);
          check_field("in_error", want.err, status_bus.in_error);
          check_field("error_cause", want.cause, status_bus.error_cause);
          check_field("error_code", want.code, status_bus.error_code);
          check_field("ticks_in_mode", want.ticks, status_bus.ticks_in_mode);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        status_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(0, 4);
        status_bus.ready <= 1'b0;
      end else begin
        status_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("mode_supervisor_with_watchdog verification failed");
      $finish;
    end
  end

  task automatic queue_cmd(logic [3:0] act, logic [3:0] tgt, logic [7:0] det);
    command_t c;
    c.act = act;
    c.tgt = tgt;
    c.det = det;
    pending_cmds.push_back(c);
  endtask

  // Queue a command with random side fields so every input bit toggles.
  task automatic queue_rand(logic [3:0] act);
    queue_cmd(act, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  // Mostly tick runs and legal commands so the watchdog gets exercised;
  // set-mode is biased toward calibration, the rest is noise.
  task automatic queue_random_phase(int unsigned count);
    int unsigned made;
    int unsigned pick;
    int unsigned run;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        run = $urandom_range(1, 8);
        repeat (run) queue_rand(msw_pkg::ACT_TICK);
        made += run;
      end else begin
        if (pick < 55) begin
          if ($urandom_range(0, 2) == 0) begin
            queue_cmd(msw_pkg::ACT_SET, msw_pkg::MODE_CALIB, 8'($urandom_range(0, 255)));
          end else begin
            queue_rand(msw_pkg::ACT_SET);
          end
        end else if (pick < 62) queue_rand(msw_pkg::ACT_START);
        else if (pick < 67) queue_rand(msw_pkg::ACT_PAUSE);
        else if (pick < 72) queue_rand(msw_pkg::ACT_STOP);
        else if (pick < 77) queue_rand(msw_pkg::ACT_RETURN);
        else if (pick < 82) queue_rand(msw_pkg::ACT_SEARCH);
        else if (pick < 87) queue_rand(msw_pkg::ACT_ERROR);
        else if (pick < 94) queue_rand(msw_pkg::ACT_RECOVER);
        else if (pick < 96) queue_rand(msw_pkg::ACT_BEGIN);
        else queue_rand(4'($urandom_range(10, 15)));
        made++;
      end
    end
  endtask

  // Writes both limit registers back to back; valid stays up between
  // the two transfers.
  task automatic load_limits(logic [msw_pkg::TicksW-1:0] calib,
                             logic [msw_pkg::TicksW-1:0] watch);
    limit_bus.index <= msw_pkg::REG_CALIB_LIMIT;
    limit_bus.data  <= calib;
    limit_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!limit_bus.ready);
    calib_limit_q = calib;
    limit_bus.index <= msw_pkg::REG_MODE_LIMIT;
    limit_bus.data  <= watch;
    do @(posedge clk_i); while (!limit_bus.ready);
    mode_limit_q = watch;
    limit_bus.valid <= 1'b0;
  endtask

  // Sender holds off until every queued command is out and every
  // predicted status has come back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || cmd_bus.valid || expected_status.size() != 0);
  endtask

  initial begin : stimulus
    logic [msw_pkg::TicksW-1:0] calib_plan[NumPhases];
    logic [msw_pkg::TicksW-1:0] watch_plan[NumPhases];

    cmd_bus.valid        = 1'b0;
    cmd_bus.action       = '0;
    cmd_bus.target_mode  = '0;
    cmd_bus.error_detail = '0;
    status_bus.ready     = 1'b0;
    limit_bus.valid      = 1'b0;
    limit_bus.index      = msw_pkg::REG_CALIB_LIMIT;
    limit_bus.data       = '0;

    // zero limits, all-ones limits (watchdog never trips), small mixes
    calib_plan = '{32'd0, 32'd3, '1, 32'd6, 32'($urandom_range(1, 8)), 32'd1};
    watch_plan = '{32'd0, 32'd6, '1, 32'd2, 32'($urandom_range(1, 12)), 32'd4};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk: tight limits so the general watchdog path trips quickly.
    idle_on = 1'b1;
    load_limits(32'd2, 32'd1);
    queue_cmd(msw_pkg::ACT_TICK, 4'd0, 8'h00);             // not armed: ignored
    queue_cmd(msw_pkg::ACT_ERROR, 4'd0, 8'hFF);            // not armed: fault stored
    queue_cmd(msw_pkg::ACT_SET, msw_pkg::MODE_CALIB, 8'h00);  // not armed: ignored
    queue_cmd(msw_pkg::ACT_BEGIN, 4'd0, 8'h00);
    queue_cmd(msw_pkg::ACT_SET, 4'hF, 8'h00);              // target out of range
    queue_cmd(4'hF, 4'hF, 8'hFF);                          // unused action code
    queue_cmd(msw_pkg::ACT_SET, msw_pkg::MODE_CALIB, 8'h00);
    repeat (3) queue_cmd(msw_pkg::ACT_TICK, 4'd0, 8'h00);  // general timeout on 2nd
    queue_cmd(msw_pkg::ACT_START, 4'd0, 8'h00);            // refused in error
    queue_cmd(msw_pkg::ACT_RETURN, 4'd0, 8'h00);           // refused in error
    queue_cmd(msw_pkg::ACT_SEARCH, 4'd0, 8'h00);           // refused in error
    queue_cmd(msw_pkg::ACT_STOP, 4'd0, 8'h00);             // no effect in error
    queue_cmd(msw_pkg::ACT_RECOVER, 4'd0, 8'h00);
    queue_cmd(msw_pkg::ACT_RECOVER, 4'd0, 8'h00);          // not in error: no effect
    queue_cmd(msw_pkg::ACT_PAUSE, 4'd0, 8'h00);            // idle: no effect
    queue_cmd(msw_pkg::ACT_START, 4'd0, 8'h00);
    queue_cmd(msw_pkg::ACT_PAUSE, 4'd0, 8'h00);
    queue_cmd(msw_pkg::ACT_SEARCH, 4'd0, 8'h00);
    repeat (2) queue_cmd(msw_pkg::ACT_TICK, 4'd0, 8'h00);  // general timeout on 2nd
    queue_cmd(msw_pkg::ACT_ERROR, 4'd0, 8'h5A);            // external fault while in error
    queue_cmd(msw_pkg::ACT_RECOVER, 4'd0, 8'h00);
    queue_cmd(msw_pkg::ACT_SET, msw_pkg::MODE_CHARGE, 8'h00);

    // Random phases, each with its own limit setting, written while idle.
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      repeat (2) @(posedge clk_i);
      // last phase runs without any idling
      idle_on = (p != NumPhases - 1) && ($urandom_range(0, 3) != 0);
      load_limits(calib_plan[p], watch_plan[p]);
      queue_random_phase(185);
    end

    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("Sent %0d commands across %0d limit settings, %0d statuses checked.",
             commands_sent, NumPhases + 1, results_checked);
    $display("Watchdog trips seen: %0d calibration, %0d supervised mode.",
             calib_trips, mode_trips);
    if (error_count == 0) begin
      $display("mode_supervisor_with_watchdog verification clean");
    end else begin
      $display("mode_supervisor_with_watchdog verification failed");
    end
    $finish;
  end

endmodule
